// ===== rtl/core/pia_pkg.sv =====
// Shared types, widths and constants of the pixel input adaptation unit.
`timescale 1ns / 1ps
`default_nettype none

package pia_pkg;

    // Field widths.
    localparam int PIX_W   = 16;
    localparam int LEVEL_W = 18;
    localparam int IDX_W   = 14;
    localparam int RATE_W  = 16;

    // Configuration port geometry.
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // Default geometry of the retina.
    localparam int RETINA_PIXELS_DEF = 16384;
    localparam int EYES_DEF          = 2;

    // Largest level that an entry can hold.
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = {LEVEL_W{1'b1}};

    // Reset values of the rate registers (about 0.3 and 0.1 in Q0.16).
    localparam logic [RATE_W-1:0] UP_RATE_RST   = 16'd19661;
    localparam logic [RATE_W-1:0] DOWN_RATE_RST = 16'd6554;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_ENABLE    = 2'd0;
    localparam logic [1:0] REG_BINOCULAR = 2'd1;
    localparam logic [1:0] REG_UP_RATE   = 2'd2;
    localparam logic [1:0] REG_DOWN_RATE = 2'd3;

    // Item functions.
    localparam logic FUNC_ADAPT = 1'b0;
    localparam logic FUNC_CLEAR = 1'b1;

    // Eye codes.
    localparam logic EYE_RIGHT = 1'b0;
    localparam logic EYE_LEFT  = 1'b1;

    // Current configuration as seen by the datapath and sequencer.
    typedef struct packed {
        logic              enable;
        logic              binocular;
        logic [RATE_W-1:0] up_rate;
        logic [RATE_W-1:0] down_rate;
    } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/core/pia_ram.sv =====
// Generic single-port synchronous RAM with a registered read.
`timescale 1ns / 1ps
`default_nettype none

module pia_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 32768,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    addr,
    input  wire logic [WIDTH-1:0] wdata,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One access per cycle: write, and read the old contents.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/pia_cfg.sv =====
// APB-style configuration registers of the pixel input adaptation unit.
`timescale 1ns / 1ps
`default_nettype none

module pia_cfg
    import pia_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    output cfg_t                    cfg
);

    logic              enable_reg;
    logic              binocular_reg;
    logic [RATE_W-1:0] up_rate_reg;
    logic [RATE_W-1:0] down_rate_reg;
    logic [1:0]        reg_index;
    logic              wr_en;

    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign wr_en     = psel && penable && pwrite;

    // Register writes in the access phase.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg    <= 1'b0;
            binocular_reg <= 1'b0;
            up_rate_reg   <= UP_RATE_RST;
            down_rate_reg <= DOWN_RATE_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_index)
                REG_ENABLE:    enable_reg    <= pwdata[0];
                REG_BINOCULAR: binocular_reg <= pwdata[0];
                REG_UP_RATE:   up_rate_reg   <= pwdata[RATE_W-1:0];
                REG_DOWN_RATE: down_rate_reg <= pwdata[RATE_W-1:0];
                default:       ;
            endcase
        end
    end

    // Read mux.
    always_comb
    begin
        unique case (reg_index)
            REG_ENABLE:    prdata = {{(PDATA_W-1){1'b0}}, enable_reg};
            REG_BINOCULAR: prdata = {{(PDATA_W-1){1'b0}}, binocular_reg};
            REG_UP_RATE:   prdata = {{(PDATA_W-RATE_W){1'b0}}, up_rate_reg};
            REG_DOWN_RATE: prdata = {{(PDATA_W-RATE_W){1'b0}}, down_rate_reg};
            default:       prdata = '0;
        endcase
    end

    assign cfg.enable    = enable_reg;
    assign cfg.binocular = binocular_reg;
    assign cfg.up_rate   = up_rate_reg;
    assign cfg.down_rate = down_rate_reg;

endmodule

`default_nettype wire

// ===== rtl/core/pia_datapath.sv =====
// Level update arithmetic: registered products, then rounding and saturation.
`timescale 1ns / 1ps
`default_nettype none

module pia_datapath
    import pia_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               capture,
    input  wire cfg_t               cfg,
    input  wire logic [LEVEL_W-1:0] level,
    input  wire logic [PIX_W-1:0]   pix,
    output logic      [PIX_W-1:0]   adapted,
    output logic      [LEVEL_W-1:0] level_held,
    output logic      [LEVEL_W-1:0] next_level
);

    localparam int KEEP_W = RATE_W + 1;
    localparam int KP_W   = LEVEL_W + KEEP_W;
    localparam int IP_W   = 2 * RATE_W;
    localparam int SUM_W  = KP_W + 1;
    localparam int RND_W  = SUM_W - 16;

    localparam logic [KEEP_W-1:0] ONE_Q16    = {1'b1, {RATE_W{1'b0}}};
    localparam logic [SUM_W-1:0]  ROUND_HALF = SUM_W'(32768);

    logic [KEEP_W-1:0]  keep_factor;
    logic [KP_W-1:0]    keep_prod;
    logic [IP_W-1:0]    in_prod;
    logic [LEVEL_W-1:0] diff;
    logic [PIX_W-1:0]   adapted_next;
    logic [KP_W-1:0]    keep_prod_reg;
    logic [IP_W-1:0]    in_prod_reg;
    logic [PIX_W-1:0]   adapted_reg;
    logic [LEVEL_W-1:0] level_reg;
    logic [SUM_W-1:0]   acc;
    logic [RND_W-1:0]   rounded;

    // level*(1 - down_rate) and up_rate*input; the level term never goes negative.
    assign keep_factor = ONE_Q16 - {1'b0, cfg.down_rate};
    assign keep_prod   = {{KEEP_W{1'b0}}, level} * {{LEVEL_W{1'b0}}, keep_factor};
    assign in_prod     = {{RATE_W{1'b0}}, cfg.up_rate} * {{PIX_W{1'b0}}, pix};

    // Input minus level, clamped at zero.
    assign diff         = {{(LEVEL_W-PIX_W){1'b0}}, pix} - level;
    assign adapted_next = ({{(LEVEL_W-PIX_W){1'b0}}, pix} > level) ? diff[PIX_W-1:0] : '0;

    // Product stage.
    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            keep_prod_reg <= keep_prod;
            in_prod_reg   <= in_prod;
            adapted_reg   <= adapted_next;
            level_reg     <= level;
        end
    end

    // Sum, round half up and saturate.
    assign acc        = {1'b0, keep_prod_reg} + {{(SUM_W-IP_W){1'b0}}, in_prod_reg} + ROUND_HALF;
    assign rounded    = acc[SUM_W-1:16];
    assign next_level = (rounded > {{(RND_W-LEVEL_W){1'b0}}, LEVEL_MAX})
                        ? LEVEL_MAX : rounded[LEVEL_W-1:0];

    assign adapted    = adapted_reg;
    assign level_held = level_reg;

endmodule

`default_nettype wire

// ===== rtl/core/pixel_input_adaptation_unit.sv =====
// Top level of the pixel input adaptation unit: sequencer, store and result register.
//
//   Channel  Direction  Handshake          Payload
//   in       input      in_valid/in_stall  func, eye, pixel_index, pixel_value
//   out      output     out_valid/out_stall adapted_pixel, new_level, echo_index, cleared
//   cfg      input      APB psel/penable   paddr, pwdata, prdata
//
// An adapt item steps through accept, store read, multiply, then sum and write back,
// an order set by the registered store read and the registered products.
// A clear item with enable set sweeps the store one entry per cycle, then emits its
// beat: the first RETINA_PIXELS entries in mono mode, all of them in binocular mode.
// After reset all EYES*RETINA_PIXELS entries of the store are swept to zero before the
// first item is taken. The result register takes a new beat while the previous one is
// taken; a stalled output holds the sequencer in its last step.
`timescale 1ns / 1ps
`default_nettype none

module pixel_input_adaptation_unit
    import pia_pkg::*;
#(
    parameter int RETINA_PIXELS = RETINA_PIXELS_DEF,
    parameter int EYES          = EYES_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // Input channel.
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               func,
    input  wire logic               eye,
    input  wire logic [IDX_W-1:0]   pixel_index,
    input  wire logic [PIX_W-1:0]   pixel_value,
    // Output channel.
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic      [PIX_W-1:0]   adapted_pixel,
    output logic      [LEVEL_W-1:0] new_level,
    output logic      [IDX_W-1:0]   echo_index,
    output logic                    cleared,
    // Configuration port.
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready
);

    localparam int DEPTH  = EYES * RETINA_PIXELS;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SLOT_W = 18;

    localparam logic [SLOT_W-1:0] RP_SLOT      = SLOT_W'(RETINA_PIXELS);
    localparam logic [AW-1:0]     LAST_ALL     = AW'(DEPTH - 1);
    localparam logic [AW-1:0]     LAST_RIGHT   = AW'(RETINA_PIXELS - 1);
    localparam logic              HAS_TWO_EYES = (EYES >= 2);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_READ  = 5'b00010,
        ST_MULT  = 5'b00100,
        ST_SUM   = 5'b01000,
        ST_CLEAR = 5'b10000
    } state_t;

    cfg_t               cfg;
    state_t             state_reg;
    state_t             state_next;
    logic               in_accept;
    logic               two_eyes;
    logic               in_range;
    logic [SLOT_W-1:0]  slot_wide;
    logic [AW-1:0]      slot_reg;
    logic [AW-1:0]      clr_cnt_reg;
    logic [AW-1:0]      clr_last_reg;
    logic               clr_item_reg;
    logic               func_reg;
    logic               in_range_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [PIX_W-1:0]   pix_reg;
    logic               mem_we;
    logic [AW-1:0]      mem_addr;
    logic [LEVEL_W-1:0] mem_wdata;
    logic [LEVEL_W-1:0] mem_rdata;
    logic               dp_capture;
    logic [PIX_W-1:0]   dp_adapted;
    logic [LEVEL_W-1:0] dp_level;
    logic [LEVEL_W-1:0] dp_next;
    logic               out_free;
    logic               emit;
    logic               clr_done;
    logic               out_valid_reg;
    logic [PIX_W-1:0]   adapted_pixel_reg;
    logic [LEVEL_W-1:0] new_level_reg;
    logic [IDX_W-1:0]   echo_index_reg;
    logic               cleared_reg;
    logic [PIX_W-1:0]   res_adapted;
    logic [LEVEL_W-1:0] res_level;

    // Configuration registers.
    pia_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Item decode at the input.
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign two_eyes  = HAS_TWO_EYES && cfg.binocular;
    assign in_range  = ({{(SLOT_W-IDX_W){1'b0}}, pixel_index} < RP_SLOT);
    assign slot_wide = {{(SLOT_W-IDX_W){1'b0}}, pixel_index}
                       + ((two_eyes && (eye == EYE_LEFT)) ? RP_SLOT : '0);

    // Handshake on the result register.
    assign out_free = !out_valid_reg || !out_stall;
    assign emit     = (state_reg == ST_SUM) && out_free;
    assign clr_done = (clr_cnt_reg == clr_last_reg);

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (func == FUNC_ADAPT)
                    begin
                        state_next = ST_READ;
                    end
                    else if (cfg.enable)
                    begin
                        state_next = ST_CLEAR;
                    end
                    else
                    begin
                        state_next = ST_SUM;
                    end
                end
            end
            ST_READ:  state_next = ST_MULT;
            ST_MULT:  state_next = ST_SUM;
            ST_SUM:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_CLEAR:
            begin
                if (clr_done)
                begin
                    state_next = clr_item_reg ? ST_SUM : ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // Control state; a reset starts a full sweep of the store.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            clr_last_reg <= LAST_ALL;
            clr_item_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_accept)
            begin
                clr_cnt_reg  <= '0;
                clr_last_reg <= two_eyes ? LAST_ALL : LAST_RIGHT;
                clr_item_reg <= 1'b1;
            end
            else if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
        end
    end

    // Item payload held for the whole of its processing.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            func_reg     <= func;
            in_range_reg <= in_range;
            idx_reg      <= pixel_index;
            pix_reg      <= pixel_value;
            slot_reg     <= slot_wide[AW-1:0];
        end
    end

    // Store port: sweep writes, item read, write back on the last step.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_addr  = slot_reg;
        mem_wdata = dp_next;
        if (state_reg == ST_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_addr  = clr_cnt_reg;
            mem_wdata = '0;
        end
        else if (emit && (func_reg == FUNC_ADAPT) && in_range_reg && cfg.enable)
        begin
            mem_we = 1'b1;
        end
    end

    pia_ram #(
        .WIDTH (LEVEL_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // Update arithmetic.
    assign dp_capture = (state_reg == ST_MULT);

    pia_datapath u_datapath (
        .clk        (clk),
        .capture    (dp_capture),
        .cfg        (cfg),
        .level      (mem_rdata),
        .pix        (pix_reg),
        .adapted    (dp_adapted),
        .level_held (dp_level),
        .next_level (dp_next)
    );

    // Result fields by item kind.
    always_comb
    begin
        if (func_reg == FUNC_CLEAR)
        begin
            res_adapted = '0;
            res_level   = '0;
        end
        else if (!in_range_reg)
        begin
            res_adapted = pix_reg;
            res_level   = '0;
        end
        else if (!cfg.enable)
        begin
            res_adapted = pix_reg;
            res_level   = dp_level;
        end
        else
        begin
            res_adapted = dp_adapted;
            res_level   = dp_next;
        end
    end

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            adapted_pixel_reg <= res_adapted;
            new_level_reg     <= res_level;
            echo_index_reg    <= idx_reg;
            cleared_reg       <= (func_reg == FUNC_CLEAR);
        end
    end

    assign out_valid     = out_valid_reg;
    assign adapted_pixel = adapted_pixel_reg;
    assign new_level     = new_level_reg;
    assign echo_index    = echo_index_reg;
    assign cleared       = cleared_reg;

endmodule

`default_nettype wire
